// ===== design/nprj_pkg.sv =====
`default_nettype none

package nprj_pkg;

   // fixed field widths
   localparam int G_BITS   = 16;
   localparam int OUT_BITS = 32;

   // ln(2) in Q.32
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;

   // taylor series of exp(-r): terms after the constant one
   localparam int TAY_TERMS = 14;

   // reciprocals for floor(x / i), x < 2^32: floor(x * m >> (32 + l)), l = clog2(i)
   localparam logic [32:0] TAY_RECIP [2:TAY_TERMS] = '{
      33'd4294967296, 33'd5726623062, 33'd4294967296, 33'd6871947674,
      33'd5726623062, 33'd4908534053, 33'd4294967296, 33'd7635497416,
      33'd6871947674, 33'd6247225158, 33'd5726623062, 33'd5286113596,
      33'd4908534053
   };
   localparam int TAY_SHIFT [2:TAY_TERMS] = '{33, 34, 34, 35, 35, 35, 35, 36, 36, 36, 36, 36, 36};

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_COEF_C     = 2'd0,
      CSR_COEF_D     = 2'd1,
      CSR_NORM_SCALE = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [G_BITS-1:0]        g_value;
      logic signed [31:0]       measured_density;
      logic                     last_sample;
   } nprj_req_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] residual;
      logic signed [OUT_BITS-1:0] slope_c;
      logic signed [OUT_BITS-1:0] slope_d;
      logic signed [OUT_BITS-1:0] slope_norm;
      logic                       last_result;
      logic                       saturated;
   } nprj_rsp_type;

endpackage

`default_nettype wire

// ===== design/nonresonant_pdf_residual_jacobian.sv =====
`default_nettype none

// Nonresonant tunneling density with residual and Jacobian. One sample is
// accepted at every clock edge where start is high and busy is low; busy is
// high while reset is held and in the cycle after it. The datapath is a fixed
// 150-stage pipeline: three 30-stage square roots, a 39-stage exponent divider
// (38 quotient bits), a 6-stage ln2 range reduction, a 27-stage Taylor series
// (one multiply and one reciprocal multiply per term) and four parallel
// 35-stage output dividers (34 quotient bits). A new sample can enter at every
// clock. Each result is on rsp_data with rsp_strobe for exactly one cycle, in
// sample order, after its sample has passed through all stages; the receiver
// must take it then. Write coef_c, coef_d and norm_scale only while no sample
// is in flight.
module nonresonant_pdf_residual_jacobian import nprj_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  nprj_req_type req_data,
   output logic         rsp_strobe,
   output nprj_rsp_type rsp_data,
   input  logic         csr_write_enable,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_write_data
);

   // stage map
   localparam int SQ_STEPS  = 30;
   localparam int QA_W      = 38;
   localparam int RED_STEPS = 6;
   localparam int DV_W      = 34;
   localparam int S_IN      = 0;
   localparam int S_PRD     = S_IN + 1;
   localparam int S_SQ      = S_PRD + SQ_STEPS;
   localparam int S_MUL     = S_SQ + 1;
   localparam int S_KK      = S_MUL + 1;
   localparam int S_MK      = S_KK + 1;
   localparam int S_K2      = S_MK + 1;
   localparam int S_QA      = S_K2 + QA_W + 1;
   localparam int S_A       = S_QA + 1;
   localparam int S_RED_END = S_A + RED_STEPS;
   localparam int S_T1      = S_RED_END + 1;
   localparam int S_TAY_END = S_T1 + 2 * (TAY_TERMS - 1);
   localparam int S_E       = S_TAY_END + 1;
   localparam int S_NE      = S_E + 1;
   localparam int S_NK1     = S_NE + 1;
   localparam int S_NK      = S_NK1 + 1;
   localparam int S_DIV     = S_NK + DV_W + 1;
   localparam int S_SGN     = S_DIV + 1;
   localparam int S_OUT     = S_SGN + 1;

   localparam logic signed [36:0] OUT_MAX_W = 37'sd2147483647;
   localparam logic signed [36:0] OUT_MIN_W = -37'sd2147483648;

   typedef struct packed {
      logic               vld;
      logic               last;
      logic [15:0]        gv;
      logic [15:0]        hv;
      logic signed [31:0] meas;
      logic [31:0]        gh;
      logic [29:0]        sg;
      logic [29:0]        sh;
      logic [29:0]        sq;
      logic signed [54:0] pc;
      logic signed [54:0] pd;
      logic [31:0]        hh;
      logic [45:0]        d0;
      logic [61:0]        d1;
      logic [61:0]        d2;
      logic signed [55:0] kk;
      logic               neg_k;
      logic [31:0]        mk;
      logic [63:0]        k2;
      logic               ez;
      logic [36:0]        rd;
      logic [5:0]         n;
      logic [31:0]        term;
      logic [31:0]        tx;
      logic signed [33:0] sum;
      logic [32:0]        e;
      logic               neg_n;
      logic [63:0]        ne;
      logic [63:0]        pl;
      logic [63:0]        ph;
      logic [95:0]        nk;
      logic signed [36:0] res_w;
      logic signed [35:0] sc_w;
      logic signed [35:0] sd_w;
      logic signed [35:0] sn_w;
      logic [31:0]        o_res;
      logic [31:0]        o_sc;
      logic [31:0]        o_sd;
      logic [31:0]        o_sn;
      logic               o_sat;
   } pipe_type;

   pipe_type    pipe_ff [0:S_OUT];
   pipe_type    pipe_in [0:S_OUT];

   logic [23:0] coef_c_ff, coef_c_in;
   logic [23:0] coef_d_ff, coef_d_in;
   logic [31:0] norm_ff, norm_in;
   logic        busy_ff, busy_in;

   logic [59:0] sq_rem_ff  [0:2][0:SQ_STEPS-1];
   logic [59:0] sq_rem_in  [0:2][0:SQ_STEPS-1];
   logic [29:0] sq_root_ff [0:2][0:SQ_STEPS-1];
   logic [29:0] sq_root_in [0:2][0:SQ_STEPS-1];

   logic [QA_W-1:0] qa_quot;
   logic            qa_ovf;
   logic [DV_W-1:0] dm_quot, dc_quot, dd_quot, dn_quot;
   logic            dm_ovf, dc_ovf, dd_ovf, dn_ovf;

   function automatic logic signed [35:0] signed_mag(input logic [DV_W-1:0] q,
                                                     input logic ovf, input logic neg);
      logic [35:0] m;
      m = ovf ? (36'd1 << DV_W) : 36'(q);
      return neg ? -$signed(m) : $signed(m);
   endfunction

   // returns {clipped flag, value}
   function automatic logic [32:0] clip_out(input logic signed [36:0] v);
      logic [32:0] r;
      if (v > OUT_MAX_W)      r = {1'b1, OUT_MAX_W[31:0]};
      else if (v < OUT_MIN_W) r = {1'b1, OUT_MIN_W[31:0]};
      else                    r = {1'b0, v[31:0]};
      return r;
   endfunction

   // configuration writes
   always_comb begin
      coef_c_in = coef_c_ff;
      coef_d_in = coef_d_ff;
      norm_in   = norm_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_COEF_C:     coef_c_in = csr_write_data[23:0];
            CSR_COEF_D:     coef_d_in = csr_write_data[23:0];
            CSR_NORM_SCALE: norm_in   = csr_write_data;
            default: ;
         endcase
      end
   end

   assign busy_in = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_c_ff <= '0;
         coef_d_ff <= '0;
         norm_ff   <= 32'd65536;
      end else begin
         coef_c_ff <= coef_c_in;
         coef_d_ff <= coef_d_in;
         norm_ff   <= norm_in;
      end
      busy_ff <= busy_in;
   end

   assign busy = busy_ff;

   // square roots of g, 1-g and g(1-g), one root bit per stage
   always_comb begin
      logic [59:0] rem_p;
      logic [29:0] root_p;
      logic [60:0] trial;
      logic [59:0] x0 [0:2];
      x0[0] = {pipe_ff[S_PRD].gv, 44'b0};
      x0[1] = {pipe_ff[S_PRD].hv, 44'b0};
      x0[2] = {pipe_ff[S_PRD].gh, 28'b0};
      for (int u = 0; u < 3; u++) begin
         for (int k = 0; k < SQ_STEPS; k++) begin
            rem_p  = (k == 0) ? x0[u] : sq_rem_ff[u][k-1];
            root_p = (k == 0) ? '0 : sq_root_ff[u][k-1];
            trial  = (61'(root_p) << (SQ_STEPS - k)) + (61'd1 << (2 * (SQ_STEPS - 1 - k)));
            sq_rem_in[u][k]  = rem_p;
            sq_root_in[u][k] = root_p;
            if (61'(rem_p) >= trial) begin
               sq_rem_in[u][k]  = rem_p - trial[59:0];
               sq_root_in[u][k] = root_p | (30'd1 << (SQ_STEPS - 1 - k));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      sq_rem_ff  <= sq_rem_in;
      sq_root_ff <= sq_root_in;
   end

   // exponent quotient k^2 / (1-g)
   nprj_div #(.NUM_W(64), .DEN_W(16), .Q_W(QA_W)) u_div_qa (
      .clock (clock),
      .num   (pipe_ff[S_K2].k2),
      .den   (pipe_ff[S_K2].hv),
      .quot  (qa_quot),
      .ovf   (qa_ovf)
   );

   // output quotients
   nprj_div #(.NUM_W(78), .DEN_W(46), .Q_W(DV_W)) u_div_model (
      .clock (clock),
      .num   ({pipe_ff[S_NK].ne, 14'b0}),
      .den   (pipe_ff[S_NK].d0),
      .quot  (dm_quot),
      .ovf   (dm_ovf)
   );

   nprj_div #(.NUM_W(102), .DEN_W(62), .Q_W(DV_W)) u_div_c (
      .clock (clock),
      .num   ({pipe_ff[S_NK].nk, 6'b0}),
      .den   (pipe_ff[S_NK].d1),
      .quot  (dc_quot),
      .ovf   (dc_ovf)
   );

   nprj_div #(.NUM_W(102), .DEN_W(62), .Q_W(DV_W)) u_div_d (
      .clock (clock),
      .num   ({pipe_ff[S_NK].nk, 6'b0}),
      .den   (pipe_ff[S_NK].d2),
      .quot  (dd_quot),
      .ovf   (dd_ovf)
   );

   nprj_div #(.NUM_W(63), .DEN_W(46), .Q_W(DV_W)) u_div_norm (
      .clock (clock),
      .num   ({pipe_ff[S_NK].e, 30'b0}),
      .den   (pipe_ff[S_NK].d0),
      .quot  (dn_quot),
      .ovf   (dn_ovf)
   );

   // main pipeline: each stage passes the transaction on and fills its own fields
   always_comb begin
      logic [63:0]        prod;
      logic [64:0]        rprod;
      logic [55:0]        kabs;
      logic [36:0]        trial;
      logic signed [33:0] sum_c;
      logic [32:0]        clip_r;
      logic [32:0]        clip_c;
      logic [32:0]        clip_d;
      logic [32:0]        clip_n;
      prod   = '0;
      rprod  = '0;
      kabs   = '0;
      trial  = '0;
      sum_c  = '0;
      clip_r = '0;
      clip_c = '0;
      clip_d = '0;
      clip_n = '0;
      for (int t = 0; t <= S_OUT; t++) begin
         if (t == S_IN) begin
            pipe_in[t]      = '0;
            pipe_in[t].vld  = start && !busy_ff;
            pipe_in[t].last = req_data.last_sample;
            pipe_in[t].gv   = (req_data.g_value == '0) ? 16'd1 : req_data.g_value;
            pipe_in[t].hv   = 16'(17'h10000 - 17'(pipe_in[t].gv));
            pipe_in[t].meas = req_data.measured_density;
         end else begin
            pipe_in[t] = pipe_ff[t-1];
         end

         if (t == S_PRD) begin
            pipe_in[t].gh = 32'(pipe_ff[t-1].gv) * 32'(pipe_ff[t-1].hv);
         end

         // products with the coefficients and the denominators
         if (t == S_MUL) begin
            pipe_in[t].sg = sq_root_ff[0][SQ_STEPS-1];
            pipe_in[t].sh = sq_root_ff[1][SQ_STEPS-1];
            pipe_in[t].sq = sq_root_ff[2][SQ_STEPS-1];
            pipe_in[t].pc = 55'($signed(coef_c_ff))
                          * 55'($signed({1'b0, sq_root_ff[0][SQ_STEPS-1]}));
            pipe_in[t].pd = 55'($signed(coef_d_ff))
                          * 55'($signed({1'b0, sq_root_ff[1][SQ_STEPS-1]}));
            pipe_in[t].hh = 32'(pipe_ff[t-1].hv) * 32'(pipe_ff[t-1].hv);
            pipe_in[t].d0 = 46'(pipe_ff[t-1].hv) * 46'(sq_root_ff[2][SQ_STEPS-1]);
         end

         if (t == S_KK) begin
            pipe_in[t].kk = 56'(pipe_ff[t-1].pc) - 56'(pipe_ff[t-1].pd);
            pipe_in[t].d1 = 62'(pipe_ff[t-1].hh) * 62'(pipe_ff[t-1].sh);
            pipe_in[t].d2 = 62'(pipe_ff[t-1].hh) * 62'(pipe_ff[t-1].sg);
         end

         // magnitude of k in Q.24
         if (t == S_MK) begin
            kabs = pipe_ff[t-1].kk[55] ? 56'(-pipe_ff[t-1].kk) : 56'(pipe_ff[t-1].kk);
            pipe_in[t].neg_k = pipe_ff[t-1].kk[55];
            pipe_in[t].mk    = kabs[53:22];
         end

         if (t == S_K2) begin
            pipe_in[t].k2 = 64'(pipe_ff[t-1].mk) * 64'(pipe_ff[t-1].mk);
         end

         // exponent a = q / 2; a at or beyond 32 gives zero
         if (t == S_A) begin
            pipe_in[t].ez = qa_ovf;
            pipe_in[t].rd = qa_quot[QA_W-1:1];
            pipe_in[t].n  = '0;
         end

         // a = n * ln2 + r
         for (int m = 0; m < RED_STEPS; m++) begin
            if (t == S_A + 1 + m) begin
               trial = 37'(LN2_Q32) << (RED_STEPS - 1 - m);
               if (pipe_ff[t-1].rd >= trial) begin
                  pipe_in[t].rd = pipe_ff[t-1].rd - trial;
                  pipe_in[t].n[RED_STEPS-1-m] = 1'b1;
               end
            end
         end

         // first taylor term
         if (t == S_T1) begin
            pipe_in[t].term = pipe_ff[t-1].rd[31:0];
            pipe_in[t].sum  = 34'sh1_0000_0000 - $signed(34'(pipe_ff[t-1].rd[31:0]));
         end

         // further terms: term * r >> 32, then divide by i
         for (int i = 2; i <= TAY_TERMS; i++) begin
            if (t == S_T1 + 2 * (i - 2) + 1) begin
               prod = 64'(pipe_ff[t-1].term) * 64'(pipe_ff[t-1].rd[31:0]);
               pipe_in[t].tx = prod[63:32];
            end
            if (t == S_T1 + 2 * (i - 2) + 2) begin
               rprod = 65'(pipe_ff[t-1].tx) * 65'(TAY_RECIP[i]);
               pipe_in[t].term = 32'(rprod >> TAY_SHIFT[i]);
               if ((i % 2) == 1)
                  pipe_in[t].sum = pipe_ff[t-1].sum - $signed(34'(pipe_in[t].term));
               else
                  pipe_in[t].sum = pipe_ff[t-1].sum + $signed(34'(pipe_in[t].term));
            end
         end

         if (t == S_E) begin
            sum_c = pipe_ff[t-1].sum[33] ? '0 : pipe_ff[t-1].sum;
            pipe_in[t].e     = pipe_ff[t-1].ez ? '0 : 33'($unsigned(sum_c) >> pipe_ff[t-1].n);
            pipe_in[t].neg_n = norm_ff[31];
         end

         if (t == S_NE) begin
            pipe_in[t].ne = 64'(norm_ff[31] ? 32'(-norm_ff) : norm_ff) * 64'(pipe_ff[t-1].e);
         end

         // norm * e * |k| in two partial products
         if (t == S_NK1) begin
            pipe_in[t].pl = 64'(pipe_ff[t-1].ne[31:0]) * 64'(pipe_ff[t-1].mk);
            pipe_in[t].ph = 64'(pipe_ff[t-1].ne[63:32]) * 64'(pipe_ff[t-1].mk);
         end

         if (t == S_NK) begin
            pipe_in[t].nk = 96'(pipe_ff[t-1].pl) + {pipe_ff[t-1].ph, 32'b0};
         end

         // signs and residual
         if (t == S_SGN) begin
            pipe_in[t].res_w = 37'(signed_mag(dm_quot, dm_ovf, pipe_ff[t-1].neg_n))
                             - 37'(pipe_ff[t-1].meas);
            pipe_in[t].sc_w  = signed_mag(dc_quot, dc_ovf,
                                          !(pipe_ff[t-1].neg_n ^ pipe_ff[t-1].neg_k));
            pipe_in[t].sd_w  = signed_mag(dd_quot, dd_ovf,
                                          pipe_ff[t-1].neg_n ^ pipe_ff[t-1].neg_k);
            pipe_in[t].sn_w  = signed_mag(dn_quot, dn_ovf, 1'b0);
         end

         // saturation to the output range
         if (t == S_OUT) begin
            clip_r = clip_out(pipe_ff[t-1].res_w);
            clip_c = clip_out(37'(pipe_ff[t-1].sc_w));
            clip_d = clip_out(37'(pipe_ff[t-1].sd_w));
            clip_n = clip_out(37'(pipe_ff[t-1].sn_w));
            pipe_in[t].o_res = clip_r[31:0];
            pipe_in[t].o_sc  = clip_c[31:0];
            pipe_in[t].o_sd  = clip_d[31:0];
            pipe_in[t].o_sn  = clip_n[31:0];
            pipe_in[t].o_sat = clip_r[32] | clip_c[32] | clip_d[32] | clip_n[32];
         end

         // reset empties every stage
         if (reset) begin
            pipe_in[t].vld = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pipe_ff <= pipe_in;
   end

   // result transaction
   assign rsp_strobe            = pipe_ff[S_OUT].vld;
   assign rsp_data.residual     = pipe_ff[S_OUT].o_res;
   assign rsp_data.slope_c      = pipe_ff[S_OUT].o_sc;
   assign rsp_data.slope_d      = pipe_ff[S_OUT].o_sd;
   assign rsp_data.slope_norm   = pipe_ff[S_OUT].o_sn;
   assign rsp_data.last_result  = pipe_ff[S_OUT].last;
   assign rsp_data.saturated    = pipe_ff[S_OUT].o_sat;

   // sqrt of g is the floor root
   assert property (@(posedge clock) disable iff (reset)
      pipe_ff[S_SQ].vld |->
         (61'(sq_root_ff[0][SQ_STEPS-1]) * 61'(sq_root_ff[0][SQ_STEPS-1])
            <= 61'({pipe_ff[S_SQ].gv, 44'b0}))
         && ((61'(sq_root_ff[0][SQ_STEPS-1]) + 61'd1) * (61'(sq_root_ff[0][SQ_STEPS-1]) + 61'd1)
            > 61'({pipe_ff[S_SQ].gv, 44'b0})))
      else $error("sqrt of g is not the floor root");

   // range reduction leaves r below ln2
   assert property (@(posedge clock) disable iff (reset)
      pipe_ff[S_RED_END].vld |-> pipe_ff[S_RED_END].rd < 37'(LN2_Q32))
      else $error("reduced exponent not below ln2");

   // taylor sum of exp(-r) stays positive
   assert property (@(posedge clock) disable iff (reset)
      pipe_ff[S_TAY_END].vld |-> !pipe_ff[S_TAY_END].sum[33])
      else $error("taylor sum went negative");

   // no result strobe right after reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_strobe)
      else $error("result strobe after reset");

endmodule

`default_nettype wire

// ===== design/nprj_div.sv =====
`default_nettype none

module nprj_div #(
   parameter int NUM_W = 64,
   parameter int DEN_W = 16,
   parameter int Q_W   = 38
) (
   input  logic             clock,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [Q_W-1:0]   quot,
   output logic             ovf
);

   localparam int W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

   logic [NUM_W-1:0] rem_ff [0:Q_W];
   logic [NUM_W-1:0] rem_in [0:Q_W];
   logic [DEN_W-1:0] den_ff [0:Q_W];
   logic [DEN_W-1:0] den_in [0:Q_W];
   logic [Q_W-1:0]   q_ff   [0:Q_W];
   logic [Q_W-1:0]   q_in   [0:Q_W];
   logic             ovf_ff [0:Q_W];
   logic             ovf_in [0:Q_W];

   // restoring division, one quotient bit per stage, quotient known to fit unless ovf
   always_comb begin
      logic [W-1:0] trial;
      trial = '0;
      rem_in[0] = num;
      den_in[0] = den;
      q_in[0]   = '0;
      ovf_in[0] = W'(num) >= (W'(den) << Q_W);
      for (int s = 1; s <= Q_W; s++) begin
         rem_in[s] = rem_ff[s-1];
         den_in[s] = den_ff[s-1];
         q_in[s]   = q_ff[s-1];
         ovf_in[s] = ovf_ff[s-1];
         trial = W'(den_ff[s-1]) << (Q_W - s);
         if (W'(rem_ff[s-1]) >= trial) begin
            rem_in[s] = rem_ff[s-1] - NUM_W'(trial);
            q_in[s][Q_W-s] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
      ovf_ff <= ovf_in;
   end

   assign quot = q_ff[Q_W];
   assign ovf  = ovf_ff[Q_W];

endmodule

`default_nettype wire

// ===== tb/nonresonant_pdf_residual_jacobian_tb.sv =====
`timescale 1ns / 100ps

import nprj_pkg::*;

// predicts density, residual and jacobian per sample and checks results in order
class density_scoreboard;
   logic signed [23:0] coef_c = 0;
   logic signed [23:0] coef_d = 0;
   logic signed [31:0] norm_scale = 32'sd65536;
   nprj_rsp_type pending_results[$];
   int errors = 0;

   function logic [63:0] isqrt(logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // exp(-a), a in Q.32, result in Q0.32
   function logic [63:0] decay(logic [63:0] a);
      logic [63:0] n, r, term;
      logic signed [63:0] sum;
      n = a / 64'(LN2_Q32);
      r = a - n * 64'(LN2_Q32);
      term = 64'd1 << 32;
      sum = 64'sd1 <<< 32;
      for (int i = 1; i <= 14; i++) begin
         term = ((term * r) >> 32) / i;
         if (i % 2 == 1) sum = sum - $signed(term);
         else sum = sum + $signed(term);
      end
      if (sum < 0) sum = 0;
      return (n >= 63) ? 64'd0 : (64'(sum) >> n);
   endfunction

   // floor(num * 2^sh / den) saturated to 64 bits
   function logic [63:0] scaled_quotient(logic [127:0] num, logic [127:0] den, int sh);
      logic [127:0] q;
      q = (num << sh) / den;
      return (q[127:64] != 0) ? '1 : q[63:0];
   endfunction

   function logic signed [63:0] signed_mag(logic [63:0] mag, bit neg);
      if (mag > (64'd1 << 62)) mag = 64'd1 << 62;
      return neg ? -$signed(mag) : $signed(mag);
   endfunction

   function logic [31:0] clip(logic signed [63:0] v, inout bit sat);
      if (v > 64'sd2147483647) begin
         v = 64'sd2147483647;
         sat = 1;
      end
      if (v < -64'sd2147483648) begin
         v = -64'sd2147483648;
         sat = 1;
      end
      return v[31:0];
   endfunction

   function void set_register(csr_index_type idx, logic [31:0] value);
      case (idx)
         CSR_COEF_C: coef_c = value[23:0];
         CSR_COEF_D: coef_d = value[23:0];
         CSR_NORM_SCALE: norm_scale = value;
         default: ;
      endcase
   endfunction

   function void note_sample(nprj_req_type t);
      logic [63:0] gv, hv, sg, sh, sq, mk, k2, qa, e, mn, ne, hh, tmp;
      logic signed [63:0] c, d, nrm, meas, kk, model;
      logic [127:0] nk;
      bit neg_k, neg_n, sat;
      nprj_rsp_type res;
      sat = 0;
      gv = 64'(t.g_value);
      if (gv == 0) gv = 1;
      hv = 64'd65536 - gv;
      sg = isqrt(gv << 44);
      sh = isqrt(hv << 44);
      sq = isqrt((gv * hv) << 28);
      c = coef_c;
      d = coef_d;
      nrm = norm_scale;
      meas = t.measured_density;
      kk = c * $signed(sg) - d * $signed(sh);
      neg_k = kk < 0;
      tmp = neg_k ? -kk : kk;
      mk = tmp >> 22;
      k2 = mk * mk;
      qa = k2 / hv;
      if (qa >= (64'd1 << 38)) e = 0;
      else e = decay((qa << 16) >> 17);
      neg_n = nrm < 0;
      mn = neg_n ? -nrm : nrm;
      ne = mn * e;
      hh = hv * hv;
      nk = 128'(ne) * 128'(mk);
      model = signed_mag(scaled_quotient(128'(ne), 128'(hv) * 128'(sq), 14), neg_n);
      res.residual = clip(model - meas, sat);
      res.slope_c = clip(signed_mag(scaled_quotient(nk, 128'(hh) * 128'(sh), 6),
                                    !(neg_n ^ neg_k)), sat);
      res.slope_d = clip(signed_mag(scaled_quotient(nk, 128'(hh) * 128'(sg), 6),
                                    neg_n ^ neg_k), sat);
      res.slope_norm = clip(signed_mag(scaled_quotient(128'(e), 128'(hv) * 128'(sq), 30),
                                       1'b0), sat);
      res.last_result = t.last_sample;
      res.saturated = sat;
      pending_results.push_back(res);
   endfunction

   function void check_result(nprj_rsp_type got);
      nprj_rsp_type want;
      if (pending_results.size() == 0) begin
         $display("%0t: unexpected result %h", $time, got);
         errors++;
         return;
      end
      want = pending_results.pop_front();
      if (got.residual !== want.residual) begin
         $display("%0t: residual expected %h actual %h", $time, want.residual, got.residual);
         errors++;
      end
      if (got.slope_c !== want.slope_c) begin
         $display("%0t: slope_c expected %h actual %h", $time, want.slope_c, got.slope_c);
         errors++;
      end
      if (got.slope_d !== want.slope_d) begin
         $display("%0t: slope_d expected %h actual %h", $time, want.slope_d, got.slope_d);
         errors++;
      end
      if (got.slope_norm !== want.slope_norm) begin
         $display("%0t: slope_norm expected %h actual %h", $time, want.slope_norm,
                  got.slope_norm);
         errors++;
      end
      if (got.last_result !== want.last_result) begin
         $display("%0t: last_result expected %b actual %b", $time, want.last_result,
                  got.last_result);
         errors++;
      end
      if (got.saturated !== want.saturated) begin
         $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                  got.saturated);
         errors++;
      end
   endfunction
endclass

module nonresonant_pdf_residual_jacobian_tb;
   localparam int PIPE_CYCLES = 150;
   localparam int CYCLE_LIMIT = 600000;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   nprj_req_type req_data = '0;
   logic rsp_strobe;
   nprj_rsp_type rsp_data;
   logic csr_write_enable = 0;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_write_data = '0;
   int cycle_count = 0;
   density_scoreboard board = new();

   nonresonant_pdf_residual_jacobian i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) board.check_result(rsp_data);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // mostly short gaps, some runs without gaps, a few long ones
   function int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // one input transaction, start stays high when no gap follows
   task send_sample(logic [15:0] g, logic [31:0] meas, logic last_flag);
      nprj_req_type t;
      int gap;
      t.g_value = g;
      t.measured_density = meas;
      t.last_sample = last_flag;
      start <= 1;
      req_data <= t;
      do @(posedge clock); while (busy);
      board.note_sample(t);
      gap = pick_gap();
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task drain();
      start <= 0;
      @(posedge clock);
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (PIPE_CYCLES / 10) @(posedge clock);
   endtask

   task write_register(csr_index_type idx, logic [31:0] value);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 0;
      board.set_register(idx, value);
   endtask

   task set_model(logic [31:0] c, logic [31:0] d, logic [31:0] nrm);
      write_register(CSR_COEF_C, c);
      write_register(CSR_COEF_D, d);
      write_register(CSR_NORM_SCALE, nrm);
   endtask

   function logic [15:0] random_g();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return 16'($urandom_range(0, 40));
      if (roll == 1) return 16'($urandom_range(65495, 65535));
      return 16'($urandom);
   endfunction

   function logic [31:0] random_density();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
   endfunction

   task random_batch(int count);
      for (int i = 0; i < count; i++)
         send_sample(random_g(), random_density(), (i == count - 1) || ($urandom_range(0, 15) == 0));
   endtask

   // small signed Q8.16 value of moderate size
   function logic [31:0] moderate_coef();
      return 32'($signed($urandom_range(0, 6 << 16)) - (3 << 16));
   endfunction

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes of g, density and last flag, reset coefficients
      send_sample(16'd0, 32'd0, 1'b0);
      send_sample(16'd1, 32'h7fffffff, 1'b0);
      send_sample(16'd65535, 32'h80000000, 1'b1);
      send_sample(16'd32768, 32'hffffffff, 1'b0);
      send_sample(16'h5555, 32'h55555555, 1'b0);
      send_sample(16'haaaa, 32'haaaaaaaa, 1'b1);
      drain();

      // directed: realistic model, then extreme coefficients
      set_model(32'h00020000, 32'h00010000, 32'h00010000);
      send_sample(16'd0, 32'd0, 1'b0);
      send_sample(16'd100, 32'h00001000, 1'b0);
      send_sample(16'd30000, 32'hfffff000, 1'b0);
      send_sample(16'd65535, 32'd0, 1'b1);
      drain();
      set_model(32'h007fffff, 32'h00800000, 32'h80000000);
      send_sample(16'd1, 32'd0, 1'b0);
      send_sample(16'd32768, 32'h7fffffff, 1'b0);
      send_sample(16'd65535, 32'h80000000, 1'b1);
      drain();
      set_model(32'h00800000, 32'h007fffff, 32'h7fffffff);
      send_sample(16'd1, 32'd0, 1'b0);
      send_sample(16'd40000, 32'd0, 1'b0);
      send_sample(16'd65535, 32'hffffffff, 1'b1);
      drain();
      set_model(32'h00000001, 32'hffffffff, 32'hffffffff);
      send_sample(16'd2, 32'd1, 1'b0);
      send_sample(16'd65534, 32'd0, 1'b1);
      drain();

      // random: moderate coefficients with occasional extremes
      for (int phase = 0; phase < 8; phase++) begin
         if (phase == 7)
            set_model(32'h007fffff, 32'h007fffff, 32'h7fffffff);
         else
            set_model(moderate_coef(), moderate_coef(),
                      (phase % 3 == 0) ? $urandom :
                      32'($signed($urandom_range(0, 4 << 16)) - (2 << 16)));
         random_batch(75);
         // hold off until the pipeline is empty
         if (phase == 2) drain();
         random_batch(75);
         drain();
      end

      if (board.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
